/* sv/fpcd_pkg.sv */
// ----------------------------------------------------------------------------
// fpcd_pkg
// Shared constants and helpers for the FPC double decompressor.
// ----------------------------------------------------------------------------
package fpcd_pkg;

  localparam int unsigned DATA_W             = 64;
  localparam int unsigned CODE_W             = 3;
  localparam int unsigned NBYTES_W           = 4;
  localparam int unsigned TABLE_BITS_DEFAULT = 10;

  localparam int unsigned FCM_SHIFT  = 6;
  localparam int unsigned DFCM_SHIFT = 2;
  localparam int unsigned FCM_TOP    = 48;
  localparam int unsigned DFCM_TOP   = 40;

  localparam logic [NBYTES_W-1:0] FULL_BYTES = 4'd8;

  function automatic logic [DATA_W-1:0] kept_mask(input logic [CODE_W-1:0] code);
    logic [NBYTES_W-1:0] nbytes;
    logic [DATA_W-1:0]   mask;
    nbytes = {1'b0, code} + {3'b000, code[CODE_W-1]};
    if (nbytes >= FULL_BYTES) begin
      mask = '1;
    end else begin
      mask = ~({DATA_W{1'b1}} << {nbytes[2:0], 3'b000});
    end
    return mask;
  endfunction

endpackage

/* sv/fpcd_in_if.sv */
// ----------------------------------------------------------------------------
// fpcd_in_if
// Encoded double channel: predictor select, byte-count code and residual.
// ----------------------------------------------------------------------------
interface fpcd_in_if;
  logic                            valid;
  logic                            ready;
  logic                            use_stride_predictor;
  logic [fpcd_pkg::CODE_W-1:0]     byte_code;
  logic [fpcd_pkg::DATA_W-1:0]     residual;

  modport source (
    output valid, use_stride_predictor, byte_code, residual,
    input  ready
  );
  modport sink (
    input  valid, use_stride_predictor, byte_code, residual,
    output ready
  );
endinterface

/* sv/fpcd_out_if.sv */
// ----------------------------------------------------------------------------
// fpcd_out_if
// Decoded double channel: 64-bit IEEE bit pattern.
// ----------------------------------------------------------------------------
interface fpcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [fpcd_pkg::DATA_W-1:0] value_bits;

  modport source (
    output valid, value_bits,
    input  ready
  );
  modport sink (
    input  valid, value_bits,
    output ready
  );
endinterface

/* sv/fpc_double_decompressor_unit.sv */
// ----------------------------------------------------------------------------
// fpc_double_decompressor_unit
// FCM / DFCM value stage of an FPC double decompressor.
//
//   Channel  Role  Payload
//   enc      sink  use_stride_predictor, byte_code, residual
//   dec      src   value_bits
//
// A beat is decoded in the cycle it is accepted; enc.ready then drops while
// the prediction tables are read, so the next beat waits for that read.
// After reset both tables are cleared one entry per cycle, all 2**TABLE_BITS
// entries (1024 by default), with enc.ready low.
// Two output entries absorb stalls on dec; enc also stalls when both are full.
// ----------------------------------------------------------------------------
module fpc_double_decompressor_unit #(
  parameter int unsigned TABLE_BITS = fpcd_pkg::TABLE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  fpcd_in_if.sink     enc,
  fpcd_out_if.source  dec
);

  logic                        core_ready;
  logic                        space;
  logic                        accept;
  logic [fpcd_pkg::DATA_W-1:0] value_bits;

  assign enc.ready = core_ready && space;
  assign accept    = enc.valid && enc.ready;

  fpcd_core #(.TABLE_BITS(TABLE_BITS)) u_core (
    .clk                  (clk),
    .rst                  (rst),
    .accept               (accept),
    .ready                (core_ready),
    .use_stride_predictor (enc.use_stride_predictor),
    .byte_code            (enc.byte_code),
    .residual             (enc.residual),
    .value_bits           (value_bits)
  );

  fpcd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (value_bits),
    .space     (space),
    .dst       (dec)
  );

endmodule

/* sv/fpcd_ram.sv */
// ----------------------------------------------------------------------------
// fpcd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fpcd_ram #(
  parameter int unsigned WIDTH = fpcd_pkg::DATA_W,
  parameter int unsigned DEPTH = 2 ** fpcd_pkg::TABLE_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/fpcd_core.sv */
// ----------------------------------------------------------------------------
// fpcd_core
// Prediction state: FCM and DFCM tables, hashes, last value and predictions.
// ----------------------------------------------------------------------------
module fpcd_core #(
  parameter int unsigned TABLE_BITS = fpcd_pkg::TABLE_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  output logic                        ready,
  input  logic                        use_stride_predictor,
  input  logic [fpcd_pkg::CODE_W-1:0] byte_code,
  input  logic [fpcd_pkg::DATA_W-1:0] residual,
  output logic [fpcd_pkg::DATA_W-1:0] value_bits
);

  localparam int unsigned DEPTH = 2 ** TABLE_BITS;
  localparam int unsigned DW    = fpcd_pkg::DATA_W;

  logic                  clearing;
  logic [TABLE_BITS-1:0] clear_addr;
  logic                  pending;

  logic [TABLE_BITS-1:0] fcm_hash;
  logic [TABLE_BITS-1:0] dfcm_hash;
  logic [DW-1:0]         previous_value;
  logic [DW-1:0]         fcm_prediction;
  logic [DW-1:0]         dfcm_prediction;

  logic [DW-1:0]         value_hold;
  logic [DW-1:0]         stride_hold;
  logic                  fcm_same;
  logic                  dfcm_same;

  logic [DW-1:0]         value;
  logic [DW-1:0]         stride;
  logic [TABLE_BITS-1:0] fcm_hash_next;
  logic [TABLE_BITS-1:0] dfcm_hash_next;
  logic [DW-1:0]         fcm_wide;
  logic [DW-1:0]         dfcm_wide;

  logic                  we;
  logic [TABLE_BITS-1:0] fcm_waddr;
  logic [TABLE_BITS-1:0] dfcm_waddr;
  logic [DW-1:0]         fcm_wdata;
  logic [DW-1:0]         dfcm_wdata;
  logic [DW-1:0]         fcm_rdata;
  logic [DW-1:0]         dfcm_rdata;

  always_comb begin
    value = (residual & fpcd_pkg::kept_mask(byte_code))
          ^ (use_stride_predictor ? dfcm_prediction : fcm_prediction);
    stride = value - previous_value;
    fcm_wide  = (DW'(fcm_hash) << fpcd_pkg::FCM_SHIFT) ^ (value >> fpcd_pkg::FCM_TOP);
    dfcm_wide = (DW'(dfcm_hash) << fpcd_pkg::DFCM_SHIFT) ^ (stride >> fpcd_pkg::DFCM_TOP);
    fcm_hash_next  = fcm_wide[TABLE_BITS-1:0];
    dfcm_hash_next = dfcm_wide[TABLE_BITS-1:0];
  end

  assign value_bits = value;
  assign ready      = !clearing && !pending;

  assign we         = accept || clearing;
  assign fcm_waddr  = clearing ? clear_addr : fcm_hash;
  assign dfcm_waddr = clearing ? clear_addr : dfcm_hash;
  assign fcm_wdata  = clearing ? '0 : value;
  assign dfcm_wdata = clearing ? '0 : stride;

  fpcd_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_fcm_ram (
    .clk   (clk),
    .we    (we),
    .waddr (fcm_waddr),
    .wdata (fcm_wdata),
    .raddr (fcm_hash_next),
    .rdata (fcm_rdata)
  );

  fpcd_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_dfcm_ram (
    .clk   (clk),
    .we    (we),
    .waddr (dfcm_waddr),
    .wdata (dfcm_wdata),
    .raddr (dfcm_hash_next),
    .rdata (dfcm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing        <= 1'b1;
      clear_addr      <= '0;
      pending         <= 1'b0;
      fcm_hash        <= '0;
      dfcm_hash       <= '0;
      previous_value  <= '0;
      fcm_prediction  <= '0;
      dfcm_prediction <= '0;
    end else begin
      if (clearing) begin
        clear_addr <= clear_addr + 1'b1;
        if (clear_addr == {TABLE_BITS{1'b1}}) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        pending        <= 1'b1;
        fcm_hash       <= fcm_hash_next;
        dfcm_hash      <= dfcm_hash_next;
        previous_value <= value;
      end else if (pending) begin
        pending         <= 1'b0;
        fcm_prediction  <= fcm_same ? value_hold : fcm_rdata;
        dfcm_prediction <= value_hold + (dfcm_same ? stride_hold : dfcm_rdata);
      end
    end
  end

  // The RAM returns old data on a same-address read, so the fresh entry is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      value_hold  <= value;
      stride_hold <= stride;
      fcm_same    <= (fcm_hash_next == fcm_hash);
      dfcm_same   <= (dfcm_hash_next == dfcm_hash);
    end
  end

`ifndef SYNTH
  a_accept_when_free: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!clearing && !pending))
    else $error("beat accepted while tables busy");

  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> pending)
    else $error("prediction read not started after beat");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    pending |=> !pending)
    else $error("prediction read held longer than one cycle");

  a_clear_runs: assert property (@(posedge clk) disable iff (rst)
    (clearing && clear_addr != {TABLE_BITS{1'b1}}) |=> clearing)
    else $error("clearing pass ended early");
`endif

endmodule

/* sv/fpcd_obuf.sv */
// ----------------------------------------------------------------------------
// fpcd_obuf
// Two-entry output buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module fpcd_obuf (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [fpcd_pkg::DATA_W-1:0] push_data,
  output logic                        space,
  fpcd_out_if.source                  dst
);

  logic                        out_valid;
  logic [fpcd_pkg::DATA_W-1:0] out_data;
  logic                        skid_valid;
  logic [fpcd_pkg::DATA_W-1:0] skid_data;
  logic                        take;

  assign take           = out_valid && dst.ready;
  assign space          = !skid_valid;
  assign dst.valid      = out_valid;
  assign dst.value_bits = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid || take) begin
          out_valid <= 1'b1;
          out_data  <= push_data;
        end else begin
          skid_valid <= 1'b1;
          skid_data  <= push_data;
        end
      end else if (take) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("beat pushed into full output buffer");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !dst.ready) |=> (out_valid && $stable(out_data)))
    else $error("waiting output beat changed before it was taken");
`endif

endmodule
